// ===== src/tfn_pkg.sv =====
// Shared types and constants for the triangle face normal unit.
// No dependencies; every other file refers to it by scoped names.
package tfn_pkg;

  localparam int unsigned SqrtCells = 35;
  localparam int unsigned DivCells  = 15;
  localparam logic [15:0] MinLenReset = 16'd6;
  localparam logic signed [15:0] UnitQ14 = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
    logic signed [15:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               last_vertex;
  } out_t;

  // Data that rides along the cell rows: positions, normal signs, and one
  // magnitude (later the division remainder) per axis.
  typedef struct packed {
    in_t              pos;
    logic [2:0]       neg;
    logic [2:0][35:0] mag;
  } side_t;

  // Square root row word.
  typedef struct packed {
    side_t       side;
    logic [69:0] rad;
    logic [39:0] rem;
    logic [34:0] root;
  } sq_t;

  // Division row word.
  typedef struct packed {
    side_t            side;
    logic [34:0]      len;
    logic [2:0][14:0] quo;
  } dv_t;

endpackage

// ===== src/tfn_front.sv =====
// Front pipeline: edges, cross product, magnitudes and the sum of squares.
// Depends on tfn_pkg.
module tfn_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tfn_pkg::in_t  data_i,
  output logic          valid_o,
  output tfn_pkg::sq_t  data_o
);

  logic [5:0] vld_q;

  tfn_pkg::in_t pos1_q, pos2_q, pos3_q, pos4_q, pos5_q;
  logic signed [16:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [33:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic [2:0][33:0] mag3_q, mag4_q, mag5_q;
  logic [2:0]       neg3_q, neg4_q, neg5_q;
  logic [2:0][33:0] hh_q, hl_q, ll_q;
  logic [2:0][67:0] sq_q;
  tfn_pkg::sq_t     out_q;

  logic signed [34:0] n_d [3];
  logic signed [34:0] a_d [3];

  // Cross product differences and their magnitudes
  always_comb begin
    n_d[0] = {p0_q[33], p0_q} - {p1_q[33], p1_q};
    n_d[1] = {p2_q[33], p2_q} - {p3_q[33], p3_q};
    n_d[2] = {p4_q[33], p4_q} - {p5_q[33], p5_q};
    for (int k = 0; k < 3; k++) begin
      a_d[k] = n_d[k][34] ? -n_d[k] : n_d[k];
    end
  end

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // Advance the payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos1_q <= data_i;
      e1x_q  <= {data_i.b_x[15], data_i.b_x} - {data_i.a_x[15], data_i.a_x};
      e1y_q  <= {data_i.b_y[15], data_i.b_y} - {data_i.a_y[15], data_i.a_y};
      e1z_q  <= {data_i.b_z[15], data_i.b_z} - {data_i.a_z[15], data_i.a_z};
      e2x_q  <= {data_i.c_x[15], data_i.c_x} - {data_i.a_x[15], data_i.a_x};
      e2y_q  <= {data_i.c_y[15], data_i.c_y} - {data_i.a_y[15], data_i.a_y};
      e2z_q  <= {data_i.c_z[15], data_i.c_z} - {data_i.a_z[15], data_i.a_z};

      pos2_q <= pos1_q;
      p0_q   <= e1y_q * e2z_q;
      p1_q   <= e1z_q * e2y_q;
      p2_q   <= e1z_q * e2x_q;
      p3_q   <= e1x_q * e2z_q;
      p4_q   <= e1x_q * e2y_q;
      p5_q   <= e1y_q * e2x_q;

      pos3_q <= pos2_q;
      for (int k = 0; k < 3; k++) begin
        mag3_q[k] <= a_d[k][33:0];
        neg3_q[k] <= n_d[k][34];
      end

      pos4_q <= pos3_q;
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      for (int k = 0; k < 3; k++) begin
        hh_q[k] <= mag3_q[k][33:17] * mag3_q[k][33:17];
        hl_q[k] <= mag3_q[k][33:17] * mag3_q[k][16:0];
        ll_q[k] <= mag3_q[k][16:0] * mag3_q[k][16:0];
      end

      pos5_q <= pos4_q;
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (68'(hh_q[k]) << 34) + (68'(hl_q[k]) << 18) + 68'(ll_q[k]);
      end

      out_q.side.pos <= pos5_q;
      out_q.side.neg <= neg5_q;
      for (int k = 0; k < 3; k++) begin
        out_q.side.mag[k] <= {2'b00, mag5_q[k]};
      end
      out_q.rad  <= 70'(sq_q[0]) + 70'(sq_q[1]) + 70'(sq_q[2]);
      out_q.rem  <= '0;
      out_q.root <= '0;
    end
  end

  assign valid_o = vld_q[5];
  assign data_o  = out_q;

endmodule

// ===== src/tfn_sqrt_cell.sv =====
// One root bit of the digit-by-digit integer square root.
// Depends on tfn_pkg.
module tfn_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tfn_pkg::sq_t  data_i,
  output logic          valid_o,
  output tfn_pkg::sq_t  data_o
);

  logic         valid_q;
  tfn_pkg::sq_t data_q;
  logic [39:0]  rem_sh;
  logic [39:0]  trial;
  logic         ge;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {data_i.rem[37:0], data_i.rad[69:68]};
    trial  = {3'b000, data_i.root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.side <= data_i.side;
      data_q.rad  <= {data_i.rad[67:0], 2'b00};
      data_q.rem  <= ge ? rem_sh - trial : rem_sh;
      data_q.root <= {data_i.root[33:0], ge};
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/tfn_div_cell.sv =====
// One quotient bit of the restoring division, three axes side by side.
// Depends on tfn_pkg.
module tfn_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tfn_pkg::dv_t  data_i,
  output logic          valid_o,
  output tfn_pkg::dv_t  data_o
);

  logic         valid_q;
  tfn_pkg::dv_t data_q;
  logic [2:0]   ge;
  logic [2:0][35:0] rem_nx;

  // Compare against the length, subtract on success, shift for the next bit
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ge[k]     = data_i.side.mag[k] >= {1'b0, data_i.len};
      rem_nx[k] = ge[k] ? data_i.side.mag[k] - {1'b0, data_i.len} : data_i.side.mag[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.side.pos <= data_i.side.pos;
      data_q.side.neg <= data_i.side.neg;
      data_q.len      <= data_i.len;
      for (int k = 0; k < 3; k++) begin
        data_q.side.mag[k] <= {rem_nx[k][34:0], 1'b0};
        data_q.quo[k]      <= {data_i.quo[k][13:0], ge[k]};
      end
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/tfn_emit.sv =====
// Output stage: picks normal or fallback, then sends three vertex words.
// Depends on tfn_pkg.
module tfn_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  tfn_pkg::dv_t  data_i,
  input  logic [15:0]   min_length_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tfn_pkg::out_t out_data_o
);

  logic         full_q;
  logic [1:0]   cnt_q;
  tfn_pkg::in_t pos_q;
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic signed [15:0] nrm_d [3];
  logic         use_len;
  logic         done;
  logic         load;

  // Signed unit normal, or the up vector for short normals
  always_comb begin
    use_len = data_i.len > {19'd0, min_length_i};
    for (int k = 0; k < 3; k++) begin
      nrm_d[k] = data_i.side.neg[k] ? -{1'b0, data_i.quo[k]} : {1'b0, data_i.quo[k]};
      if (!use_len) begin
        nrm_d[k] = (k == 1) ? tfn_pkg::UnitQ14 : '0;
      end
    end
  end

  assign done    = full_q && !out_stall_i && (cnt_q == 2'd2);
  assign ready_o = !full_q || done;
  assign load    = valid_i && ready_o;

  // Count the three vertex words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      full_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done) begin
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else if (full_q && !out_stall_i) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  // Hold the triangle while its words go out
  always_ff @(posedge clk_i) begin
    if (load) begin
      pos_q <= data_i.side.pos;
      nx_q  <= nrm_d[0];
      ny_q  <= nrm_d[1];
      nz_q  <= nrm_d[2];
    end
  end

  always_comb begin
    out_data_o.norm_x      = nx_q;
    out_data_o.norm_y      = ny_q;
    out_data_o.norm_z      = nz_q;
    out_data_o.last_vertex = cnt_q == 2'd2;
    case (cnt_q)
      2'd0: begin
        out_data_o.pos_x = pos_q.a_x;
        out_data_o.pos_y = pos_q.a_y;
        out_data_o.pos_z = pos_q.a_z;
      end
      2'd1: begin
        out_data_o.pos_x = pos_q.b_x;
        out_data_o.pos_y = pos_q.b_y;
        out_data_o.pos_z = pos_q.b_z;
      end
      default: begin
        out_data_o.pos_x = pos_q.c_x;
        out_data_o.pos_y = pos_q.c_y;
        out_data_o.pos_z = pos_q.c_z;
      end
    endcase
  end

  assign out_valid_o = full_q;

endmodule

// ===== src/triangle_face_normal_unit.sv =====
// Top level of the triangle face normal unit: front pipeline, square root
// and division cell rows, and the vertex output stage. Depends on tfn_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one triangle
//   word: three vertices in signed Q8.8. Output channel (out_valid_o /
//   out_stall_i / out_data_o) gives three vertex words per triangle, in
//   order a, b, c, each with the shared Q1.14 face normal; the third word
//   has last_vertex set.
//   Path: 6 front stages, 35 square root cells, 15 divider cells and
//   1 output register from acceptance to the first vertex word.
//   Throughput: one vertex word per cycle while out_stall_i is low; the
//   output stage takes the next triangle as it sends the last word. The
//   chain advances as one unless a finished triangle waits at its end, so
//   up to 57 triangles are in flight (56 chain stages and the output stage).
//   Receiver stall: the output word holds, and once the chain's last cell
//   holds a triangle the chain and in_stall_o hold as well.
//   Reset: all valid flags clear, min_length returns to 6. cfg_we_i writes
//   min_length; write it only while no triangle is in flight.
module triangle_face_normal_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tfn_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tfn_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);

  logic [15:0]  min_len_q;
  logic         en;
  logic         emit_ready;

  logic         sq_v [tfn_pkg::SqrtCells+1];
  tfn_pkg::sq_t sq_w [tfn_pkg::SqrtCells+1];
  logic         dv_v [tfn_pkg::DivCells+1];
  tfn_pkg::dv_t dv_w [tfn_pkg::DivCells+1];

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= tfn_pkg::MinLenReset;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  // Advance the chain unless a finished triangle waits at its end
  assign en         = emit_ready || !dv_v[tfn_pkg::DivCells];
  assign in_stall_o = !en;

  tfn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (sq_v[0]),
    .data_o  (sq_w[0])
  );

  for (genvar i = 0; i < tfn_pkg::SqrtCells; i++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .data_i  (sq_w[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq_w[i+1])
    );
  end

  // Hand the root to the divider row as the length
  always_comb begin
    dv_v[0]      = sq_v[tfn_pkg::SqrtCells];
    dv_w[0].side = sq_w[tfn_pkg::SqrtCells].side;
    dv_w[0].len  = sq_w[tfn_pkg::SqrtCells].root;
    dv_w[0].quo  = '0;
  end

  for (genvar i = 0; i < tfn_pkg::DivCells; i++) begin : g_div
    tfn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[i]),
      .data_i  (dv_w[i]),
      .valid_o (dv_v[i+1]),
      .data_o  (dv_w[i+1])
    );
  end

  tfn_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (dv_v[tfn_pkg::DivCells]),
    .data_i       (dv_w[tfn_pkg::DivCells]),
    .min_length_i (min_len_q),
    .ready_o      (emit_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== test/testbench.sv =====
// Testbench for triangle_face_normal_unit: drives triangle words, predicts
// the flat-shaded vertex words and checks them in order. Depends on tfn_pkg.
`timescale 1ns / 100ps

module testbench;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  tfn_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  tfn_pkg::out_t out_data_o;
  logic          cfg_we_i = 1'b0;
  logic [15:0]   cfg_wdata_i = '0;

  // Directed row: a triangle, and an optional typed-in normal.
  typedef struct {
    tfn_pkg::in_t tri_w;
    logic         has_norm;
    logic [47:0]  norm;
  } row_t;

  logic [15:0]   min_len_q;
  tfn_pkg::out_t vertex_q[$];
  row_t          rows[$];
  int            fails = 0;
  logic          sending_done = 1'b0;

  triangle_face_normal_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Compute the face normal the way the block should: exact cross product,
  // floor square root, truncating scale to Q1.14.
  function automatic logic [47:0] face_normal(tfn_pkg::in_t t);
    logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [35:0] n[3];
    logic [35:0]        m[3];
    logic [71:0]        sq;
    logic [35:0]        root, cand;
    logic [49:0]        q;
    logic [15:0]        r[3];
    e1x = 17'(t.b_x) - 17'(t.a_x);
    e1y = 17'(t.b_y) - 17'(t.a_y);
    e1z = 17'(t.b_z) - 17'(t.a_z);
    e2x = 17'(t.c_x) - 17'(t.a_x);
    e2y = 17'(t.c_y) - 17'(t.a_y);
    e2z = 17'(t.c_z) - 17'(t.a_z);
    n[0] = 36'(e1y) * 36'(e2z) - 36'(e1z) * 36'(e2y);
    n[1] = 36'(e1z) * 36'(e2x) - 36'(e1x) * 36'(e2z);
    n[2] = 36'(e1x) * 36'(e2y) - 36'(e1y) * 36'(e2x);
    sq = '0;
    for (int k = 0; k < 3; k++) begin
      m[k] = n[k] < 0 ? 36'(-n[k]) : 36'(n[k]);
      sq += 72'(m[k]) * 72'(m[k]);
    end
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      cand = root | (36'd1 << b);
      if (72'(cand) * 72'(cand) <= sq) root = cand;
    end
    if (root <= 36'(min_len_q)) return {16'd0, 16'(tfn_pkg::UnitQ14), 16'd0};
    for (int k = 0; k < 3; k++) begin
      q = (50'(m[k]) << 14) / 50'(root);
      r[k] = n[k] < 0 ? 16'(-q) : 16'(q);
    end
    return {r[0], r[1], r[2]};
  endfunction

  // Append one directed row.
  task automatic add_row(tfn_pkg::in_t t, logic has_norm, logic [47:0] nrm);
    row_t r;
    r.tri_w    = t;
    r.has_norm = has_norm;
    r.norm     = nrm;
    rows.insert(rows.size(), r);
  endtask

  // Queue the three vertex words of one accepted triangle.
  task automatic push_vertices(tfn_pkg::in_t t, logic [47:0] nrm);
    tfn_pkg::out_t w;
    w.norm_x = nrm[47:32];
    w.norm_y = nrm[31:16];
    w.norm_z = nrm[15:0];
    w.pos_x = t.a_x; w.pos_y = t.a_y; w.pos_z = t.a_z; w.last_vertex = 1'b0;
    vertex_q.insert(vertex_q.size(), w);
    w.pos_x = t.b_x; w.pos_y = t.b_y; w.pos_z = t.b_z;
    vertex_q.insert(vertex_q.size(), w);
    w.pos_x = t.c_x; w.pos_y = t.c_y; w.pos_z = t.c_z; w.last_vertex = 1'b1;
    vertex_q.insert(vertex_q.size(), w);
  endtask

  // Send one triangle after a random gap; hold until accepted.
  task automatic send_triangle(tfn_pkg::in_t t, logic has_norm, logic [47:0] nrm);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    push_vertices(t, has_norm ? nrm : face_normal(t));
  endtask

  // Drop valid, let the pipeline drain fully, then write min_length.
  task automatic set_min_len(logic [15:0] v);
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_len_q = v;
  endtask

  function automatic tfn_pkg::in_t rand_triangle(int mode);
    tfn_pkg::in_t t;
    t = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
    // Small triangles near a random point exercise the threshold region.
    if (mode == 1) begin
      t.b_x = t.a_x + 16'($signed($urandom_range(0, 8)) - 4);
      t.b_y = t.a_y + 16'($signed($urandom_range(0, 8)) - 4);
      t.b_z = t.a_z + 16'($signed($urandom_range(0, 8)) - 4);
      t.c_x = t.a_x + 16'($signed($urandom_range(0, 8)) - 4);
      t.c_y = t.a_y + 16'($signed($urandom_range(0, 8)) - 4);
      t.c_z = t.a_z + 16'($signed($urandom_range(0, 8)) - 4);
    end
    return t;
  endfunction

  // Stimulus: directed table, then random phases under several thresholds.
  initial begin
    tfn_pkg::in_t t;
    logic [15:0]  lens[5];
    min_len_q = tfn_pkg::MinLenReset;
    add_row('0, 1'b1, {16'd0, 16'(tfn_pkg::UnitQ14), 16'd0});
    t = '0; t.b_x = 16'sh0100; t.c_y = 16'sh0100;
    add_row(t, 1'b1, {16'd0, 16'd0, 16'(tfn_pkg::UnitQ14)});
    t = '0; t.b_y = 16'sh0100; t.c_z = 16'sh0100;
    add_row(t, 1'b1, {16'(tfn_pkg::UnitQ14), 16'd0, 16'd0});
    t = '0; t.b_z = 16'sh0100; t.c_x = 16'sh0100;
    add_row(t, 1'b1, {16'd0, 16'(tfn_pkg::UnitQ14), 16'd0});
    t = '0; t.b_y = 16'sh0100; t.c_x = 16'sh0100;
    add_row(t, 1'b1, {16'd0, 16'd0, -16'(tfn_pkg::UnitQ14)});
    t = '0; t.b_x = 16'sd2; t.c_y = 16'sd3;
    add_row(t, 1'b1, {16'd0, 16'(tfn_pkg::UnitQ14), 16'd0});
    t = '0; t.b_x = 16'sd7; t.c_y = 16'sd1;
    add_row(t, 1'b1, {16'd0, 16'd0, 16'(tfn_pkg::UnitQ14)});
    t = {9{16'sh7fff}};
    add_row(t, 1'b1, {16'd0, 16'(tfn_pkg::UnitQ14), 16'd0});
    t = {9{16'sh8000}};
    add_row(t, 1'b1, {16'd0, 16'(tfn_pkg::UnitQ14), 16'd0});
    t = '0; t.a_x = 16'sh8000; t.a_y = 16'sh8000; t.a_z = 16'sh8000;
    t.b_x = 16'sh7fff; t.b_y = 16'sh8000; t.b_z = 16'sh8000;
    t.c_x = 16'sh8000; t.c_y = 16'sh7fff; t.c_z = 16'sh7fff;
    add_row(t, 1'b0, '0);
    t = {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
         16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000};
    add_row(t, 1'b0, '0);
    t = {16'sh1234, 16'shedcb, 16'sh0abc, 16'sh7000, 16'sh9000,
         16'sh0100, 16'shc000, 16'sh3fff, 16'sh8001};
    add_row(t, 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_triangle(rows[i].tri_w, rows[i].has_norm, rows[i].norm);

    // Walk thresholds, extremes among them.
    lens = '{16'd0, 16'hffff, 16'd1, 16'd300, 16'd6};
    foreach (lens[p]) begin
      set_min_len(lens[p]);
      for (int i = 0; i < 32; i++) begin
        send_triangle(rand_triangle($urandom_range(0, 1)), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;
    sending_done = 1'b1;
  end

  // Stall the output side at random, with quiet stretches.
  initial begin
    int hold;
    forever begin
      hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  // Check each accepted vertex word against the oldest expectation.
  always @(posedge clk_i) begin
    tfn_pkg::out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex word %h", $time, out_data_o);
        fails++;
      end else begin
        e = vertex_q.pop_front();
        if (e !== out_data_o) begin
          $display("%0t: expected %h actual %h", $time, e, out_data_o);
          fails++;
        end
      end
    end
  end

  // Finish once everything has drained.
  initial begin
    wait (sending_done);
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS triangle_face_normal_unit");
    end else begin
      $display("FAIL triangle_face_normal_unit");
    end
    $finish;
  end

  // Give up after a generous fixed time.
  initial begin
    #5000000;
    $display("FAIL triangle_face_normal_unit");
    $finish;
  end

endmodule

// ===== triangle_face_normal_unit.f =====
src/tfn_pkg.sv
src/tfn_front.sv
src/tfn_sqrt_cell.sv
src/tfn_div_cell.sv
src/tfn_emit.sv
src/triangle_face_normal_unit.sv
test/testbench.sv
